>>> hdl/assert_macros.svh
// concurrent assertion helpers, clocked on clk and disabled while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ASSERT_IMPL(label, ante, cons, msg)
`define ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

>>> hdl/stab_pkg.sv
`default_nettype none

package stab_pkg;

  // configuration port
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_CMP_FUNC  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REF_VAL   = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CMP_MASK  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PASS_OP   = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FAIL_OP   = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DRAW_COL  = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TAG_VAL   = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_TAG_WE    = 4'd7;

  // stencil compare functions
  localparam logic [2:0] CMP_NEVER    = 3'd0;
  localparam logic [2:0] CMP_LESS     = 3'd1;
  localparam logic [2:0] CMP_LEQUAL   = 3'd2;
  localparam logic [2:0] CMP_GREATER  = 3'd3;
  localparam logic [2:0] CMP_GEQUAL   = 3'd4;
  localparam logic [2:0] CMP_EQUAL    = 3'd5;
  localparam logic [2:0] CMP_NOTEQUAL = 3'd6;
  localparam logic [2:0] CMP_ALWAYS   = 3'd7;

  // stencil update operations
  localparam logic [2:0] OP_ZERO    = 3'd0;
  localparam logic [2:0] OP_KEEP    = 3'd1;
  localparam logic [2:0] OP_REPLACE = 3'd2;
  localparam logic [2:0] OP_INCR    = 3'd3;
  localparam logic [2:0] OP_DECR    = 3'd4;
  localparam logic [2:0] OP_INVERT  = 3'd5;

  typedef struct packed {
    logic [23:0] dest_color;
    logic [7:0]  dest_stencil;
    logic [7:0]  dest_tag;
    logic [7:0]  fragment_alpha;
  } in_t;

  typedef struct packed {
    logic [23:0] new_color;
    logic [7:0]  new_stencil;
    logic [7:0]  new_tag;
    logic        test_passed;
  } out_t;

  // exact divide by 255 of a product of two bytes: ((v + 1) * 257) >> 16
  function automatic logic [7:0] div255(input logic [15:0] v);
    logic [16:0] t;
    logic [24:0] p;
    t = {1'b0, v} + 17'd1;
    p = {t, 8'b0} + {8'b0, t};
    return p[23:16];
  endfunction

endpackage

`default_nettype wire

>>> hdl/stab_chan.sv
`default_nettype none

// one color channel of the blend: multiply, divide by 255, add and saturate
module stab_chan (
  input  wire logic       clk,
  input  wire logic       en,
  input  wire logic [7:0] dst,
  input  wire logic [7:0] src,
  input  wire logic [7:0] alpha,
  output logic [7:0]      res
);

  logic [15:0] prod_d_r, prod_s_r;
  logic [7:0]  quo_d_r, quo_s_r;
  logic [7:0]  res_r;
  logic [8:0]  sum;

  // stage 1: weighted products
  always_ff @(posedge clk) begin
    if (en) begin
      prod_d_r <= {8'b0, dst} * {8'b0, 8'd255 - alpha};
      prod_s_r <= {8'b0, src} * {8'b0, alpha};
    end
  end

  // stage 2: exact divide by 255
  always_ff @(posedge clk) begin
    if (en) begin
      quo_d_r <= stab_pkg::div255(prod_d_r);
      quo_s_r <= stab_pkg::div255(prod_s_r);
    end
  end

  // stage 3: sum with saturation at full scale
  assign sum = {1'b0, quo_d_r} + {1'b0, quo_s_r};

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= sum[8] ? 8'hFF : sum[7:0];
    end
  end

  assign res = res_r;

endmodule

`default_nettype wire

>>> hdl/stencil_test_alpha_blend_top.sv
`default_nettype none
// stencil test and alpha blend, three register stages
// throughput: one fragment per cycle; the whole pipeline holds while the
//   output register is full and out_ready is low
// reset (rst_n low, synchronous): pipeline emptied, configuration registers to defaults

`include "assert_macros.svh"

module stencil_test_alpha_blend_top (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire stab_pkg::in_t                    in_data,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output stab_pkg::out_t                        out_data,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [stab_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [stab_pkg::CFG_DATA_W-1:0]  cfg_data
);

  // configuration registers
  logic [2:0]  cmp_func_r, pass_op_r, fail_op_r;
  logic [7:0]  ref_val_r, cmp_mask_r, tag_val_r;
  logic [23:0] draw_col_r;
  logic        tag_we_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmp_func_r <= stab_pkg::CMP_ALWAYS;
      ref_val_r  <= 8'd0;
      cmp_mask_r <= 8'hFF;
      pass_op_r  <= stab_pkg::OP_KEEP;
      fail_op_r  <= stab_pkg::OP_KEEP;
      draw_col_r <= 24'd0;
      tag_val_r  <= 8'd0;
      tag_we_r   <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        stab_pkg::REG_CMP_FUNC: cmp_func_r <= cfg_data[2:0];
        stab_pkg::REG_REF_VAL:  ref_val_r  <= cfg_data[7:0];
        stab_pkg::REG_CMP_MASK: cmp_mask_r <= cfg_data[7:0];
        stab_pkg::REG_PASS_OP:  pass_op_r  <= cfg_data[2:0];
        stab_pkg::REG_FAIL_OP:  fail_op_r  <= cfg_data[2:0];
        stab_pkg::REG_DRAW_COL: draw_col_r <= cfg_data[23:0];
        stab_pkg::REG_TAG_VAL:  tag_val_r  <= cfg_data[7:0];
        stab_pkg::REG_TAG_WE:   tag_we_r   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // global advance: every stage moves unless the output is held
  logic adv;
  logic v1_r, v2_r, out_valid_r;

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v1_r        <= in_valid;
      v2_r        <= v1_r;
      out_valid_r <= v2_r;
    end
  end

  // stencil compare on masked operands
  logic [7:0] lhs, rhs;
  logic       pass;

  assign lhs = in_data.dest_stencil & cmp_mask_r;
  assign rhs = ref_val_r & cmp_mask_r;

  always_comb begin
    case (cmp_func_r)
      stab_pkg::CMP_NEVER:    pass = 1'b0;
      stab_pkg::CMP_LESS:     pass = lhs < rhs;
      stab_pkg::CMP_LEQUAL:   pass = lhs <= rhs;
      stab_pkg::CMP_GREATER:  pass = lhs > rhs;
      stab_pkg::CMP_GEQUAL:   pass = lhs >= rhs;
      stab_pkg::CMP_EQUAL:    pass = lhs == rhs;
      stab_pkg::CMP_NOTEQUAL: pass = lhs != rhs;
      default:                pass = 1'b1;
    endcase
  end

  // stencil update; unused codes keep the stored value
  logic [2:0] op;
  logic [7:0] sten, new_sten;

  assign op   = pass ? pass_op_r : fail_op_r;
  assign sten = in_data.dest_stencil;

  always_comb begin
    case (op)
      stab_pkg::OP_ZERO:    new_sten = 8'd0;
      stab_pkg::OP_REPLACE: new_sten = ref_val_r;
      stab_pkg::OP_INCR:    new_sten = (sten == 8'hFF) ? sten : sten + 8'd1;
      stab_pkg::OP_DECR:    new_sten = (sten == 8'd0) ? sten : sten - 8'd1;
      stab_pkg::OP_INVERT:  new_sten = ~sten;
      default:              new_sten = sten;
    endcase
  end

  // side data that rides along with the blend stages
  logic        pass1_r, pass2_r, pass3_r;
  logic [7:0]  sten1_r, sten2_r, sten3_r;
  logic [7:0]  tag1_r, tag2_r, tag3_r;
  logic [23:0] dcol1_r, dcol2_r, dcol3_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      pass1_r <= pass;
      sten1_r <= new_sten;
      tag1_r  <= (pass && tag_we_r) ? tag_val_r : in_data.dest_tag;
      dcol1_r <= in_data.dest_color;
      pass2_r <= pass1_r;
      sten2_r <= sten1_r;
      tag2_r  <= tag1_r;
      dcol2_r <= dcol1_r;
      pass3_r <= pass2_r;
      sten3_r <= sten2_r;
      tag3_r  <= tag2_r;
      dcol3_r <= dcol2_r;
    end
  end

  // per-channel blend pipelines
  logic [7:0] blend_r, blend_g, blend_b;

  stab_chan u_chan_r (
    .clk   (clk),
    .en    (adv),
    .dst   (in_data.dest_color[23:16]),
    .src   (draw_col_r[23:16]),
    .alpha (in_data.fragment_alpha),
    .res   (blend_r)
  );

  stab_chan u_chan_g (
    .clk   (clk),
    .en    (adv),
    .dst   (in_data.dest_color[15:8]),
    .src   (draw_col_r[15:8]),
    .alpha (in_data.fragment_alpha),
    .res   (blend_g)
  );

  stab_chan u_chan_b (
    .clk   (clk),
    .en    (adv),
    .dst   (in_data.dest_color[7:0]),
    .src   (draw_col_r[7:0]),
    .alpha (in_data.fragment_alpha),
    .res   (blend_b)
  );

  // result assembly
  assign out_valid            = out_valid_r;
  assign out_data.new_color   = pass3_r ? {blend_r, blend_g, blend_b} : dcol3_r;
  assign out_data.new_stencil = sten3_r;
  assign out_data.new_tag     = tag3_r;
  assign out_data.test_passed = pass3_r;

  // checks
  `ASSERT_IMPL(a_rise_from_stage2, $rose(out_valid_r), $past(v2_r),
    "result appeared without an item in stage 2")
  `ASSERT_NEXT(a_stall_holds, !adv, $stable(v1_r) && $stable(v2_r) && $stable(pass3_r),
    "pipeline moved during a stall")
  `ASSERT_IMPL(a_never_fails, out_valid_r && cmp_func_r == stab_pkg::CMP_NEVER,
    !out_data.test_passed, "pass reported with compare function never")
  `ASSERT_IMPL(a_ready_when_empty, !out_valid_r, in_ready,
    "input blocked with an empty output register")

endmodule

`default_nettype wire
